FILE: src/dwa_pkg.sv
// shared types, constants and helpers of the dfa word acceptor
package dwa_pkg;

	localparam int STATES_DEF  = 16;
	localparam int SYMBOLS     = 36;
	localparam int ST_W        = 4;
	localparam int SYM_W       = 6;
	localparam int ADDR_FULL_W = ST_W + SYM_W;
	localparam int MASK_W      = 36;
	localparam int COUNT_W     = 5;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT = 1'b1;

	localparam logic [MASK_W-1:0]  ALPHABET_RST    = 36'hF_FFFF_FFFF;
	localparam logic [COUNT_W-1:0] STATE_COUNT_RST = 5'd16;

	localparam logic [7:0] CHAR_A    = 8'h61;
	localparam logic [7:0] CHAR_Z    = 8'h7A;
	localparam logic [7:0] CHAR_0    = 8'h30;
	localparam logic [7:0] CHAR_9    = 8'h39;
	localparam logic [SYM_W-1:0] DIGIT_BASE = 6'd26;

	typedef enum logic [1:0] {
		FUNC_DEFINE,
		FUNC_FINAL,
		FUNC_CHAR,
		FUNC_END
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_BAD_SYMBOL,
		STATUS_BAD_STATE
	} status_t;

	typedef struct packed {
		logic            valid;
		logic [ST_W-1:0] dest;
	} entry_t;

	typedef struct packed {
		logic   rd_en;
		logic   wr_en;
		entry_t wr_data;
	} tbl_ctl_t;

	typedef struct packed {
		logic   busy;
		entry_t rd_data;
	} tbl_rsp_t;

	typedef struct packed {
		logic             ok;
		logic [SYM_W-1:0] sym;
	} sym_t;

	// letters map to 0..25, digits to 26..35
	function automatic sym_t sym_of(input logic [7:0] code);
		sym_t r;
		r.ok  = 1'b0;
		r.sym = '0;
		if (code >= CHAR_A && code <= CHAR_Z) begin
			r.ok  = 1'b1;
			r.sym = SYM_W'(code - CHAR_A);
		end else if (code >= CHAR_0 && code <= CHAR_9) begin
			r.ok  = 1'b1;
			r.sym = SYM_W'(code - CHAR_0) + DIGIT_BASE;
		end
		return r;
	endfunction

endpackage

FILE: src/dwa_cmd_if.sv
// command channel: one item per table edit, final mark, word character or end of word
interface dwa_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [3:0] src_state;
	logic [7:0] symbol_code;
	logic [3:0] dest_state;
	logic       final_flag;

	modport source (output valid, func, src_state, symbol_code, dest_state, final_flag,
		input ready);
	modport sink (input valid, func, src_state, symbol_code, dest_state, final_flag,
		output ready);
endinterface

FILE: src/dwa_result_if.sv
// result channel: one item per command
interface dwa_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [3:0] state_now;
	logic       stuck;
	logic       word_done;
	logic       accepted;

	modport source (output valid, status, state_now, stuck, word_done, accepted,
		input ready);
	modport sink (input valid, status, state_now, stuck, word_done, accepted,
		output ready);
endinterface

FILE: src/dwa_table.sv
// transition table memory with clearing pass and write-to-read forwarding
module dwa_table #(
	parameter int STATES = dwa_pkg::STATES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  dwa_pkg::tbl_ctl_t                      ctl,
	input  logic [$clog2(STATES*dwa_pkg::SYMBOLS)-1:0] rd_addr,
	input  logic [$clog2(STATES*dwa_pkg::SYMBOLS)-1:0] wr_addr,
	output dwa_pkg::tbl_rsp_t                      rsp
);
	localparam int DEPTH = STATES * dwa_pkg::SYMBOLS;
	localparam int AW    = $clog2(DEPTH);

	dwa_pkg::entry_t mem [DEPTH];
	dwa_pkg::entry_t rd_q;
	dwa_pkg::entry_t fwd_q;
	logic            fwd_hit_q;
	logic [AW-1:0]   clr_q;
	logic            busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_q     <= '0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (busy_q) begin
				if (clr_q == AW'(DEPTH - 1)) begin
					busy_q <= 1'b0;
				end else begin
					clr_q <= clr_q + AW'(1);
				end
			end
			if (ctl.rd_en) begin
				fwd_hit_q <= ctl.wr_en && (wr_addr == rd_addr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (ctl.wr_en) begin
			mem[wr_addr] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			rd_q  <= mem[rd_addr];
			fwd_q <= ctl.wr_data;
		end
	end

	assign rsp.busy    = busy_q;
	assign rsp.rd_data = fwd_hit_q ? fwd_q : rd_q;
endmodule

FILE: src/dfa_word_acceptor_top.sv
// top level of the dfa word acceptor: command decode, table access, state update
// A loadable deterministic automaton. Each command item is one of: define a
// transition (first definition of a source/symbol pair wins), set or clear a
// state's final mark, feed one word character, or end the word (reports
// acceptance and returns to state 0). Every command gives exactly one result
// item. After reset the transition table is swept clear, one entry a cycle;
// no command is taken during that sweep, configuration writes are. After that
// the block takes one item per cycle while the result side keeps up; a word
// character directly behind another word character or an end of word waits
// until that item has left the command stage, since the next character's
// table address needs the state that the previous read returns. An accepted
// command passes through the command stage and then the result register.
// Configuration is to be written by the user only while the block is idle;
// the block itself does not enforce it.
module dfa_word_acceptor_top #(
	parameter int STATES = dwa_pkg::STATES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	dwa_cmd_if.sink                           cmd,
	dwa_result_if.source                      result,
	input  logic                              cfg_we,
	input  logic [dwa_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [dwa_pkg::MASK_W-1:0]        cfg_wdata
);
	localparam int DEPTH = STATES * dwa_pkg::SYMBOLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int ST_W  = dwa_pkg::ST_W;
	localparam int FIN_N = 1 << ST_W;

	// configuration registers
	logic [dwa_pkg::MASK_W-1:0]  alphabet_q;
	logic [dwa_pkg::COUNT_W-1:0] state_count_q;

	// automaton state
	logic [ST_W-1:0]  cur_q;
	logic             stuck_q;
	logic [FIN_N-1:0] final_q;

	// command stage: item waiting for its table read data
	logic                        valid_s1;
	dwa_pkg::func_t              func_s1;
	logic [ST_W-1:0]             src_s1;
	logic [ST_W-1:0]             dest_s1;
	logic                        flag_s1;
	logic                        sym_ok_s1;
	logic [dwa_pkg::SYM_W-1:0]   sym_s1;
	logic [AW-1:0]               addr_s1;

	// result register
	logic                        out_valid_q;
	dwa_pkg::status_t            status_q;
	logic [ST_W-1:0]             state_now_q;
	logic                        stuck_out_q;
	logic                        done_q;
	logic                        acc_q;

	// table interface
	dwa_pkg::tbl_ctl_t           tbl_ctl;
	dwa_pkg::tbl_rsp_t           tbl_rsp;
	logic [AW-1:0]               rd_addr;

	// decode at accept
	dwa_pkg::func_t              cmd_func;
	dwa_pkg::sym_t               cmd_sym;
	logic [ST_W-1:0]             rd_state;
	logic [dwa_pkg::ADDR_FULL_W-1:0] addr_full;
	logic                        cmd_acc;
	logic                        adv;
	logic                        state_dep;

	// command stage evaluation
	logic                        sym_in;
	logic                        src_bad;
	logic                        dest_bad;
	dwa_pkg::status_t            status_n;
	logic [ST_W-1:0]             cur_n;
	logic                        stuck_n;
	logic                        acc_n;
	logic                        tbl_write;

	assign cmd_func = dwa_pkg::func_t'(cmd.func);
	assign cmd_sym  = dwa_pkg::sym_of(cmd.symbol_code);

	// stage drains when the result register is free or being emptied
	assign adv = valid_s1 && (!out_valid_q || result.ready);

	// an item in the stage that moves the automaton blocks the next character
	assign state_dep = valid_s1 && (func_s1 == dwa_pkg::FUNC_CHAR ||
		func_s1 == dwa_pkg::FUNC_END);

	assign cmd.ready = !tbl_rsp.busy && (!valid_s1 || adv) &&
		!(state_dep && cmd_func == dwa_pkg::FUNC_CHAR);
	assign cmd_acc = cmd.valid && cmd.ready;

	// table address: state * 36 + symbol
	assign rd_state  = (cmd_func == dwa_pkg::FUNC_CHAR) ? cur_q : cmd.src_state;
	assign addr_full = {1'b0, rd_state, 5'b0} + {4'b0, rd_state, 2'b0} +
		{4'b0, cmd_sym.sym};
	assign rd_addr   = AW'(addr_full);

	// range checks against the smaller of state_count and STATES
	assign sym_in   = sym_ok_s1 && alphabet_q[sym_s1];
	assign src_bad  = ({1'b0, src_s1} >= state_count_q) || (32'(src_s1) >= STATES);
	assign dest_bad = ({1'b0, dest_s1} >= state_count_q) || (32'(dest_s1) >= STATES);

	always_comb begin
		status_n  = dwa_pkg::STATUS_OK;
		cur_n     = cur_q;
		stuck_n   = stuck_q;
		acc_n     = 1'b0;
		tbl_write = 1'b0;
		case (func_s1)
			dwa_pkg::FUNC_DEFINE: begin
				if (!sym_in) begin
					status_n = dwa_pkg::STATUS_BAD_SYMBOL;
				end else if (src_bad || dest_bad) begin
					status_n = dwa_pkg::STATUS_BAD_STATE;
				end else begin
					// first definition of a pair wins
					tbl_write = !tbl_rsp.rd_data.valid;
				end
			end
			dwa_pkg::FUNC_FINAL: begin
				if (src_bad) begin
					status_n = dwa_pkg::STATUS_BAD_STATE;
				end
			end
			dwa_pkg::FUNC_CHAR: begin
				if (!stuck_q) begin
					if (!sym_ok_s1 || !tbl_rsp.rd_data.valid) begin
						stuck_n = 1'b1;
					end else begin
						cur_n = tbl_rsp.rd_data.dest;
					end
				end
			end
			dwa_pkg::FUNC_END: begin
				acc_n = !stuck_q && final_q[cur_q];
			end
			default: begin
				status_n = dwa_pkg::STATUS_OK;
			end
		endcase
	end

	assign tbl_ctl.rd_en         = cmd_acc;
	assign tbl_ctl.wr_en         = adv && tbl_write;
	assign tbl_ctl.wr_data.valid = 1'b1;
	assign tbl_ctl.wr_data.dest  = dest_s1;

	dwa_table #(
		.STATES (STATES)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.rd_addr (rd_addr),
		.wr_addr (addr_s1),
		.rsp     (tbl_rsp)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_q    <= dwa_pkg::ALPHABET_RST;
			state_count_q <= dwa_pkg::STATE_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				dwa_pkg::CFG_ALPHABET:    alphabet_q    <= cfg_wdata;
				dwa_pkg::CFG_STATE_COUNT: state_count_q <= cfg_wdata[dwa_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// command stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// command stage payload
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			func_s1   <= cmd_func;
			src_s1    <= cmd.src_state;
			dest_s1   <= cmd.dest_state;
			flag_s1   <= cmd.final_flag;
			sym_ok_s1 <= cmd_sym.ok;
			sym_s1    <= cmd_sym.sym;
			addr_s1   <= rd_addr;
		end
	end

	// automaton state and final marks, updated when the item commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			stuck_q <= 1'b0;
			final_q <= '0;
		end else if (adv) begin
			if (func_s1 == dwa_pkg::FUNC_END) begin
				// word over: back to the start state
				cur_q   <= '0;
				stuck_q <= 1'b0;
			end else begin
				cur_q   <= cur_n;
				stuck_q <= stuck_n;
			end
			if (func_s1 == dwa_pkg::FUNC_FINAL && !src_bad) begin
				final_q[src_s1] <= flag_s1;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			status_q    <= status_n;
			state_now_q <= cur_n;
			stuck_out_q <= stuck_n;
			done_q      <= (func_s1 == dwa_pkg::FUNC_END);
			acc_q       <= acc_n;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.status    = status_q;
	assign result.state_now = state_now_q;
	assign result.stuck     = stuck_out_q;
	assign result.word_done = done_q;
	assign result.accepted  = acc_q;

	// no command is taken while the table is being cleared
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_rsp.busy |-> !cmd_acc)
		else $error("command accepted during table clear");

	// acceptance only on an end-of-word result of a word that is not stuck
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.accepted) |-> (result.word_done && !result.stuck))
		else $error("accepted without a clean end of word");

	// a character never enters behind an item that still moves the state
	a_char_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		state_dep |-> !(cmd_acc && cmd_func == dwa_pkg::FUNC_CHAR))
		else $error("character read issued against a stale state");

	// a table write only ever comes from a committing define item
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_ctl.wr_en |-> (adv && func_s1 == dwa_pkg::FUNC_DEFINE && !tbl_rsp.busy))
		else $error("unexpected table write");
endmodule

FILE: bench/dfa_acceptor_checker.sv
`timescale 1ns / 1ps
// checker of the dfa word acceptor: mirrors the automaton and compares every result item
module dfa_acceptor_checker #(
	parameter int STATES = dwa_pkg::STATES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dwa_cmd_if                            cmd,
	dwa_result_if                         result,
	input  logic                          cfg_we,
	input  logic [dwa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [dwa_pkg::MASK_W-1:0]    cfg_wdata,
	output int                            fail_count,
	output int                            pending
);

	typedef struct packed {
		dwa_pkg::status_t         status;
		logic [dwa_pkg::ST_W-1:0] state_now;
		logic                     stuck;
		logic                     word_done;
		logic                     accepted;
	} outcome_t;

	logic [dwa_pkg::MASK_W-1:0]  alpha_mask;
	logic [dwa_pkg::COUNT_W-1:0] state_cnt;
	bit                          arc_valid [STATES*dwa_pkg::SYMBOLS];
	logic [dwa_pkg::ST_W-1:0]    arc_dest  [STATES*dwa_pkg::SYMBOLS];
	bit                          accepting [STATES];
	logic [dwa_pkg::ST_W-1:0]    cur_state;
	bit                          stuck_now;
	outcome_t                    outcome_q [$];
	outcome_t                    got;
	outcome_t                    want;

	// letter or digit to symbol number, -1 for anything else
	function automatic int symbol_index(input logic [7:0] code);
		if (code >= dwa_pkg::CHAR_A && code <= dwa_pkg::CHAR_Z)
			return int'(code - dwa_pkg::CHAR_A);
		if (code >= dwa_pkg::CHAR_0 && code <= dwa_pkg::CHAR_9)
			return int'(code - dwa_pkg::CHAR_0) + dwa_pkg::SYMBOLS - 10;
		return -1;
	endfunction

	function automatic outcome_t step_automaton(input dwa_pkg::func_t f,
			input logic [dwa_pkg::ST_W-1:0] src, input logic [7:0] code,
			input logic [dwa_pkg::ST_W-1:0] dest, input logic flag);
		outcome_t o;
		int       sym;
		int       lim;
		int       slot;
		sym = symbol_index(code);
		lim = (int'(state_cnt) < STATES) ? int'(state_cnt) : STATES;
		o = '0;
		o.status = dwa_pkg::STATUS_OK;
		case (f)
			dwa_pkg::FUNC_DEFINE: begin
				if (sym < 0 || !alpha_mask[sym]) begin
					o.status = dwa_pkg::STATUS_BAD_SYMBOL;
				end else if (int'(src) >= lim || int'(dest) >= lim) begin
					o.status = dwa_pkg::STATUS_BAD_STATE;
				end else begin
					// first definition of a pair wins
					slot = int'(src) * dwa_pkg::SYMBOLS + sym;
					if (!arc_valid[slot]) begin
						arc_valid[slot] = 1'b1;
						arc_dest[slot]  = dest;
					end
				end
			end
			dwa_pkg::FUNC_FINAL: begin
				if (int'(src) >= lim)
					o.status = dwa_pkg::STATUS_BAD_STATE;
				else
					accepting[src] = flag;
			end
			dwa_pkg::FUNC_CHAR: begin
				if (!stuck_now) begin
					if (sym < 0) begin
						stuck_now = 1'b1;
					end else begin
						slot = int'(cur_state) * dwa_pkg::SYMBOLS + sym;
						if (arc_valid[slot])
							cur_state = arc_dest[slot];
						else
							stuck_now = 1'b1;
					end
				end
			end
			default: begin
				o.word_done = 1'b1;
				o.accepted  = !stuck_now && accepting[cur_state];
			end
		endcase
		o.state_now = cur_state;
		o.stuck     = stuck_now;
		if (f == dwa_pkg::FUNC_END) begin
			cur_state = '0;
			stuck_now = 1'b0;
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_mask = dwa_pkg::ALPHABET_RST;
			state_cnt  = dwa_pkg::STATE_COUNT_RST;
			foreach (arc_valid[i]) begin
				arc_valid[i] = 1'b0;
				arc_dest[i]  = '0;
			end
			foreach (accepting[i])
				accepting[i] = 1'b0;
			cur_state = '0;
			stuck_now = 1'b0;
			outcome_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == dwa_pkg::CFG_ALPHABET)
					alpha_mask = cfg_wdata;
				else if (cfg_idx == dwa_pkg::CFG_STATE_COUNT)
					state_cnt = cfg_wdata[dwa_pkg::COUNT_W-1:0];
			end
			if (result.valid && result.ready) begin
				got.status    = dwa_pkg::status_t'(result.status);
				got.state_now = result.state_now;
				got.stuck     = result.stuck;
				got.word_done = result.word_done;
				got.accepted  = result.accepted;
				if (outcome_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result item with none expected: status %0d state %0d",
							$time, got.status, got.state_now);
					fail_count <= fail_count + 1;
				end else begin
					want = outcome_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display({"%0t: result mismatch: expected status %0d state %0d ",
								"stuck %0b done %0b acc %0b, got status %0d state %0d ",
								"stuck %0b done %0b acc %0b"}, $time,
								want.status, want.state_now, want.stuck, want.word_done,
								want.accepted, got.status, got.state_now, got.stuck,
								got.word_done, got.accepted);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				outcome_q.insert(outcome_q.size(),
					step_automaton(dwa_pkg::func_t'(cmd.func), cmd.src_state,
					cmd.symbol_code, cmd.dest_state, cmd.final_flag));
			pending <= outcome_q.size();
		end
	end

endmodule

FILE: bench/tb_dfa_word_acceptor_top.sv
`timescale 1ns / 1ps
// testbench top of the dfa word acceptor: stimulus, receiver stalls and verdict
module tb_dfa_word_acceptor_top;

	// generous bound on the whole run, cycles
	localparam int CYCLE_LIMIT = 1_500_000;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [dwa_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [dwa_pkg::MASK_W-1:0]    cfg_wdata;
	int                            fail_count;
	int                            pending;

	// sender side knobs and bookkeeping
	bit                            tight;        // no gaps between items in this phase
	int                            sent;         // items accepted so far
	int                            backlog_req;  // bumped to ask for one long hold-off
	logic [dwa_pkg::COUNT_W-1:0]   cur_count;    // last state_count written
	int                            cycles;

	dwa_cmd_if    cmd ();
	dwa_result_if result ();

	dfa_word_acceptor_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	dfa_acceptor_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// idle cycles before the next item: none half the time, a few long ones
	function automatic int idle_len();
		int r;
		if (tight)
			return 0;
		r = $urandom_range(19);
		if (r < 10)
			return 0;
		if (r < 16)
			return $urandom_range(1, 3);
		if (r < 19)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// offer one item and hold it until the block takes it; valid stays high
	// afterwards so that a following item can go out back to back
	task automatic push_cmd(input dwa_pkg::func_t f, input logic [3:0] src,
			input logic [7:0] code, input logic [3:0] dest, input logic flag);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid       <= 1'b1;
		cmd.func        <= f;
		cmd.src_state   <= src;
		cmd.symbol_code <= code;
		cmd.dest_state  <= dest;
		cmd.final_flag  <= flag;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		sent++;
	endtask

	// word character; the fields it does not use carry noise
	task automatic send_char(input logic [7:0] code);
		push_cmd(dwa_pkg::FUNC_CHAR, 4'($urandom), code, 4'($urandom), 1'($urandom));
	endtask

	task automatic send_end();
		push_cmd(dwa_pkg::FUNC_END, 4'($urandom), 8'($urandom), 4'($urandom),
			1'($urandom));
	endtask

	// stop offering, wait for every result, then allow for the block's latency
	task automatic settle();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one register write; cfg_we drops again before the task returns, which keeps back-to-back writes clean
	task automatic write_reg(input logic [dwa_pkg::CFG_IDX_W-1:0] idx,
			input logic [dwa_pkg::MASK_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		if (idx == dwa_pkg::CFG_STATE_COUNT)
			cur_count = data[dwa_pkg::COUNT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// receiver: random stretches of ready high and low, plus one long hold-off
	// per request so that the block backs up and stalls the sender
	initial begin
		int run;
		int backlog_seen;
		backlog_seen = 0;
		result.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (backlog_req != backlog_seen) begin
				backlog_seen = backlog_req;
				result.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				case ($urandom_range(9))
					6, 7: begin
						result.ready <= 1'b0;
						run = $urandom_range(1, 3);
					end
					8: begin
						result.ready <= 1'b0;
						run = $urandom_range(4, 12);
					end
					9: begin
						result.ready <= 1'b0;
						run = ($urandom_range(3) == 0) ? $urandom_range(30, 80) :
							$urandom_range(4, 8);
					end
					default: begin
						result.ready <= 1'b1;
						run = $urandom_range(1, 40);
					end
				endcase
				repeat (run) @(posedge clk);
			end
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int                          item_goal;
		int                          hint;
		int                          nsym;
		int                          len;
		int                          s;
		int                          src_top;
		logic [7:0]                  word_syms [5];
		logic [dwa_pkg::MASK_W-1:0]  mask;
		logic [dwa_pkg::COUNT_W-1:0] count;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_idx         = '0;
		cfg_wdata       = '0;
		cmd.valid       = 1'b0;
		cmd.func        = '0;
		cmd.src_state   = '0;
		cmd.symbol_code = '0;
		cmd.dest_state  = '0;
		cmd.final_flag  = 1'b0;
		tight           = 1'b0;
		sent            = 0;
		backlog_req     = 0;
		cur_count       = dwa_pkg::STATE_COUNT_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// registers may be written while the table is being swept clear
		write_reg(dwa_pkg::CFG_ALPHABET, dwa_pkg::ALPHABET_RST);
		write_reg(dwa_pkg::CFG_STATE_COUNT, dwa_pkg::MASK_W'(dwa_pkg::STATE_COUNT_RST));

		// ---- directed part, full alphabet and all 16 states ----
		// empty word with state 0 not final, then final
		send_end();
		push_cmd(dwa_pkg::FUNC_FINAL, 4'd0, 8'd0, 4'd0, 1'b1);
		send_end();
		// transitions at the state and symbol extremes, then a redefinition
		push_cmd(dwa_pkg::FUNC_DEFINE, 4'd0, dwa_pkg::CHAR_A, 4'd15, 1'b0);
		push_cmd(dwa_pkg::FUNC_DEFINE, 4'd15, dwa_pkg::CHAR_9, 4'd0, 1'b1);
		push_cmd(dwa_pkg::FUNC_DEFINE, 4'd15, dwa_pkg::CHAR_0, 4'd15, 1'b0);
		push_cmd(dwa_pkg::FUNC_DEFINE, 4'd0, dwa_pkg::CHAR_A, 4'd3, 1'b0);
		// codes that are no letter or digit, right at each range border too
		push_cmd(dwa_pkg::FUNC_DEFINE, 4'd1, "@", 4'd2, 1'b0);
		push_cmd(dwa_pkg::FUNC_DEFINE, 4'd1, 8'hFF, 4'd2, 1'b0);
		push_cmd(dwa_pkg::FUNC_DEFINE, 4'd1, 8'h00, 4'd2, 1'b0);
		push_cmd(dwa_pkg::FUNC_DEFINE, 4'd1, dwa_pkg::CHAR_A - 8'd1, 4'd2, 1'b0);
		push_cmd(dwa_pkg::FUNC_DEFINE, 4'd1, dwa_pkg::CHAR_Z + 8'd1, 4'd2, 1'b0);
		push_cmd(dwa_pkg::FUNC_DEFINE, 4'd1, dwa_pkg::CHAR_0 - 8'd1, 4'd2, 1'b0);
		push_cmd(dwa_pkg::FUNC_DEFINE, 4'd1, dwa_pkg::CHAR_9 + 8'd1, 4'd2, 1'b0);
		push_cmd(dwa_pkg::FUNC_FINAL, 4'd15, 8'd0, 4'd0, 1'b1);
		// a word that walks 0 -> 15 -> 15 -> 0 and is accepted
		send_char(dwa_pkg::CHAR_A);
		send_char(dwa_pkg::CHAR_0);
		send_char(dwa_pkg::CHAR_9);
		send_end();
		// missing transition: stuck stays set, word rejected
		send_char(dwa_pkg::CHAR_Z);
		send_char(dwa_pkg::CHAR_A);
		send_end();
		// a non-letter word character gets stuck as well
		send_char("@");
		send_end();
		settle();

		// fewer states and 'b' dropped from the alphabet
		write_reg(dwa_pkg::CFG_STATE_COUNT, dwa_pkg::MASK_W'(4));
		write_reg(dwa_pkg::CFG_ALPHABET,
			dwa_pkg::ALPHABET_RST & ~(dwa_pkg::MASK_W'(1) << 1));
		push_cmd(dwa_pkg::FUNC_DEFINE, 4'd0, dwa_pkg::CHAR_A + 8'd1, 4'd1, 1'b0);
		push_cmd(dwa_pkg::FUNC_DEFINE, 4'd5, dwa_pkg::CHAR_A + 8'd2, 4'd1, 1'b0);
		push_cmd(dwa_pkg::FUNC_DEFINE, 4'd0, dwa_pkg::CHAR_A + 8'd2, 4'd4, 1'b0);
		push_cmd(dwa_pkg::FUNC_FINAL, 4'd4, 8'd0, 4'd0, 1'b1);
		// the old 0 -a-> 15 arc stays usable though 15 is now out of range
		send_char(dwa_pkg::CHAR_A);
		send_end();

		// ---- random part: phases of table building followed by words ----
		item_goal = sent + 1800;
		for (int ph = 0; sent < item_goal; ph++) begin
			settle();
			if (ph == 0) begin
				write_reg(dwa_pkg::CFG_ALPHABET, '0);
				write_reg(dwa_pkg::CFG_STATE_COUNT, {31'($urandom), 5'd31});
			end else if (ph == 1) begin
				write_reg(dwa_pkg::CFG_ALPHABET, dwa_pkg::ALPHABET_RST);
				write_reg(dwa_pkg::CFG_STATE_COUNT, {31'($urandom), 5'd0});
			end else if (ph == 2) begin
				write_reg(dwa_pkg::CFG_STATE_COUNT, dwa_pkg::MASK_W'(1));
			end else if ($urandom_range(1) == 0) begin
				case ($urandom_range(9))
					0: mask = '0;
					1, 2: mask = dwa_pkg::MASK_W'({$urandom, $urandom});
					3: mask = dwa_pkg::ALPHABET_RST &
						~(dwa_pkg::MASK_W'(1) << $urandom_range(dwa_pkg::SYMBOLS - 1));
					default: mask = dwa_pkg::ALPHABET_RST;
				endcase
				case ($urandom_range(9))
					0: count = 5'd0;
					1: count = 5'd1;
					2: count = 5'd2;
					3: count = 5'($urandom_range(17, 31));
					4, 5: count = 5'd16;
					default: count = 5'($urandom_range(1, 16));
				endcase
				write_reg(dwa_pkg::CFG_ALPHABET, mask);
				write_reg(dwa_pkg::CFG_STATE_COUNT, {31'($urandom), count});
			end

			tight = ($urandom_range(3) == 0);
			// now and then the receiver holds off while items go out back to back
			if (ph % 9 == 4) begin
				backlog_req <= backlog_req + 1;
				tight = 1'b1;
			end

			hint = (cur_count == 0) ? 1 :
				((cur_count > dwa_pkg::STATES_DEF) ? dwa_pkg::STATES_DEF : int'(cur_count));
			src_top = (hint < 6) ? hint : 6;

			// a small symbol set per phase keeps words on defined arcs
			nsym = $urandom_range(2, 5);
			for (int k = 0; k < nsym; k++) begin
				s = $urandom_range(dwa_pkg::SYMBOLS - 1);
				word_syms[k] = (s < 26) ? dwa_pkg::CHAR_A + 8'(s) :
					dwa_pkg::CHAR_0 + 8'(s - 26);
			end

			// arcs for every low state and symbol of the set, with some noise
			for (int st = 0; st < src_top; st++)
				for (int k = 0; k < nsym; k++)
					if ($urandom_range(9) == 0)
						push_cmd(dwa_pkg::FUNC_DEFINE, 4'($urandom), 8'($urandom),
							4'($urandom), 1'($urandom));
					else
						push_cmd(dwa_pkg::FUNC_DEFINE, 4'(st), word_syms[k],
							4'($urandom_range(hint - 1)), 1'($urandom));

			// final marks, now and then one just past the limit
			repeat ($urandom_range(1, 3))
				push_cmd(dwa_pkg::FUNC_FINAL, 4'($urandom_range(hint)), 8'($urandom),
					4'($urandom), 1'($urandom));

			// words: mostly short, a few long, stray characters and edits mixed in,
			// and sometimes no end so that the next word runs on
			repeat ($urandom_range(3, 8)) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6);
				repeat (len)
					case ($urandom_range(19))
						0: send_char(8'($urandom));
						1: push_cmd(dwa_pkg::FUNC_FINAL, 4'($urandom_range(hint - 1)),
							8'($urandom), 4'($urandom), 1'($urandom));
						2: push_cmd(dwa_pkg::FUNC_DEFINE, 4'($urandom), 8'($urandom),
							4'($urandom), 1'($urandom));
						default: send_char(word_syms[$urandom_range(nsym - 1)]);
					endcase
				if ($urandom_range(15) != 0)
					send_end();
			end
		end

		settle();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
src/dwa_pkg.sv
src/dwa_cmd_if.sv
src/dwa_result_if.sv
src/dwa_table.sv
src/dfa_word_acceptor_top.sv
bench/dfa_acceptor_checker.sv
bench/tb_dfa_word_acceptor_top.sv
